FILE: design/wmil_pkg.sv
// Package for the wavetable morph lookup: sizes, field widths and handshake structs.
// Used by wmil_cell_store and the top module; depends on nothing.
`default_nettype none
package wmil_pkg;
   localparam int MaxBanksDefault  = 16;
   localparam int RowsDefault      = 8;
   localparam int ColumnsDefault   = 8;
   localparam int FrameSizeDefault = 256;
   localparam int FracBits         = 12;

   localparam logic OpWrite = 1'b0;
   localparam logic OpRead  = 1'b1;

   // valid and stall control for the request handshake
   typedef struct packed {
      logic valid;
      logic stall;
   } stage_ctrl_type;
endpackage
`default_nettype wire

FILE: design/wmil_ram.sv
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
`default_nettype none
module wmil_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end
   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/wmil_cell_store.sv
// Sample store: sixteen RAMs, one per parity pattern of bank, row, column and frame index.
// Depends on wmil_pkg and wmil_ram.
`default_nettype none
module wmil_cell_store
   import wmil_pkg::*;
#(
   parameter int MaxBanks  = MaxBanksDefault,
   parameter int Rows      = RowsDefault,
   parameter int Columns   = ColumnsDefault,
   parameter int FrameSize = FrameSizeDefault,
   localparam int BW = (MaxBanks > 1) ? $clog2(MaxBanks) : 1,
   localparam int RW = $clog2(Rows),
   localparam int CW = $clog2(Columns),
   localparam int FW = $clog2(FrameSize)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [BW-1:0] wr_bank,
   input  wire logic [RW-1:0] wr_row,
   input  wire logic [CW-1:0] wr_column,
   input  wire logic [FW-1:0] wr_index,
   input  wire logic [15:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [BW-1:0] rd_bank  [2],
   input  wire logic [RW-1:0] rd_row   [2],
   input  wire logic [CW-1:0] rd_column[2],
   input  wire logic [FW-1:0] rd_index [2],
   output logic signed [15:0] rd_data  [16]
);
   // each RAM holds the samples of one parity pattern; the parity bits leave the address
   localparam int BH    = (BW > 1) ? BW - 1 : 1;
   localparam int RH    = (RW > 1) ? RW - 1 : 1;
   localparam int CH    = (CW > 1) ? CW - 1 : 1;
   localparam int FH    = (FW > 1) ? FW - 1 : 1;
   localparam int AW    = BH + RH + CH + FH;
   localparam int Depth = 1 << AW;

   logic [15:0] ram_q [16];
   logic [1:0]  bank_par_ff, row_par_ff, column_par_ff, index_par_ff;

   // hold the parities of the read taps alongside the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         bank_par_ff   <= {rd_bank[1][0], rd_bank[0][0]};
         row_par_ff    <= {rd_row[1][0], rd_row[0][0]};
         column_par_ff <= {rd_column[1][0], rd_column[0][0]};
         index_par_ff  <= {rd_index[1][0], rd_index[0][0]};
      end
   end

   for (genvar k = 0; k < 16; k++) begin : g_ram
      localparam logic [3:0] Sel = 4'(k);
      logic [BW-1:0] bank_sel;
      logic [RW-1:0] row_sel;
      logic [CW-1:0] column_sel;
      logic [FW-1:0] index_sel;
      logic [AW-1:0] ra, wa;
      logic          we;

      // pick the tap whose parity this RAM holds
      assign bank_sel   = (rd_bank[0][0] == Sel[3]) ? rd_bank[0] : rd_bank[1];
      assign row_sel    = (rd_row[0][0] == Sel[2]) ? rd_row[0] : rd_row[1];
      assign column_sel = (rd_column[0][0] == Sel[1]) ? rd_column[0] : rd_column[1];
      assign index_sel  = (rd_index[0][0] == Sel[0]) ? rd_index[0] : rd_index[1];
      assign ra = {BH'(bank_sel >> 1), RH'(row_sel >> 1), CH'(column_sel >> 1),
                   FH'(index_sel >> 1)};
      assign wa = {BH'(wr_bank >> 1), RH'(wr_row >> 1), CH'(wr_column >> 1),
                   FH'(wr_index >> 1)};
      assign we = wr_en && (wr_bank[0] == Sel[3]) && (wr_row[0] == Sel[2])
                  && (wr_column[0] == Sel[1]) && (wr_index[0] == Sel[0]);

      wmil_ram #(.Width(16), .Depth(Depth)) u_ram (
         .clock  (clock),
         .wr_en  (we),
         .wr_addr(wa),
         .wr_data(wr_data),
         .rd_en  (rd_en),
         .rd_addr(ra),
         .rd_data(ram_q[k])
      );

      // route the corner from the RAM that held its tap
      assign rd_data[k] = signed'(ram_q[{bank_par_ff[Sel[3]], row_par_ff[Sel[2]],
                                         column_par_ff[Sel[1]], index_par_ff[Sel[0]]}]);
   end
endmodule
`default_nettype wire

FILE: design/wavetable_morph_interpolated_lookup_top.sv
// Wavetable morph lookup: one item per cycle, no bubbles, while the response is not stalled.
// A read passes through registered steps in order after the request transfer
// (RAM read, frame lerp, bank weight, row weight, column weight and sum, round).
// Each stage advances only while the response register can take data; writes cause no response.
// Synchronous active-high reset clears valid bits and sets bank_count to 1; store is unset.
`default_nettype none
module wavetable_morph_interpolated_lookup_top
   import wmil_pkg::*;
#(
   parameter int MaxBanks  = MaxBanksDefault,
   parameter int Rows      = RowsDefault,
   parameter int Columns   = ColumnsDefault,
   parameter int FrameSize = FrameSizeDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [4:0]         csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [3:0]         req_cell_bank,
   input  wire logic [2:0]         req_cell_row,
   input  wire logic [2:0]         req_cell_column,
   input  wire logic [7:0]         req_frame_index,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [15:0]        req_bank_pos,
   input  wire logic [14:0]        req_row_pos,
   input  wire logic [14:0]        req_column_pos,
   input  wire logic [15:0]        req_phase,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_sample_out
);
   localparam int BW = (MaxBanks > 1) ? $clog2(MaxBanks) : 1;
   localparam int RW = $clog2(Rows);
   localparam int CW = $clog2(Columns);
   localparam int FW = $clog2(FrameSize);
   localparam int GW = 16;

   logic [4:0] bank_count_ff;
   always_ff @(posedge clock) begin
      if (reset) bank_count_ff <= 5'd1;
      else if (csr_write_enable) bank_count_ff <= csr_write_data;
   end

   // global advance: whole pipeline moves while the output slot is free or drained
   logic advance;
   stage_ctrl_type ctrl;
   assign advance   = !rsp_valid || rsp_ready;
   assign ctrl      = '{valid: req_valid, stall: !advance};
   assign req_ready = !ctrl.stall;
   logic take;
   assign take = ctrl.valid && !ctrl.stall;

   // clamp one position against its last index
   function automatic logic [16:0] clamp_pos(input logic [15:0] pos, input logic [6:0] last);
      logic [18:0] cap;
      begin
         cap = {last, 12'd0};
         clamp_pos = ({3'd0, pos} > cap) ? cap[16:0] : {1'b0, pos};
      end
   endfunction

   // stage 0: split positions, frame taps, issue RAM reads
   logic [4:0] nb;
   logic [6:0] lastb;
   always_comb begin
      nb = bank_count_ff;
      if (nb == 5'd0) nb = 5'd1;
      if (32'(nb) > MaxBanks) nb = 5'(MaxBanks);
      lastb = 7'(nb - 5'd1);
   end
   logic [16:0] bp, rp, cp;
   assign bp = clamp_pos(req_bank_pos, lastb);
   assign rp = clamp_pos({1'b0, req_row_pos}, 7'(Rows - 1));
   assign cp = clamp_pos({1'b0, req_column_pos}, 7'(Columns - 1));

   logic [4:0] bl, rl, cl;
   assign bl = bp[16:12];
   assign rl = rp[16:12];
   assign cl = cp[16:12];
   logic [BW-1:0] rb[2];
   logic [RW-1:0] rr[2];
   logic [CW-1:0] rc[2];
   logic [FW-1:0] ri[2];
   logic [FW+GW-1:0] pp;
   assign pp = {req_phase, {FW{1'b0}}};
   assign rb[0] = BW'(bl);
   assign rb[1] = (7'(bl) >= lastb) ? BW'(bl) : BW'(bl + 5'd1);
   assign rr[0] = RW'(rl);
   assign rr[1] = (32'(rl) >= Rows - 1) ? RW'(rl) : RW'(rl + 5'd1);
   assign rc[0] = CW'(cl);
   assign rc[1] = (32'(cl) >= Columns - 1) ? CW'(cl) : CW'(cl + 5'd1);
   assign ri[0] = pp[FW+GW-1:GW];
   assign ri[1] = ri[0] + FW'(1);

   logic wr_ok;
   assign wr_ok = take && (req_operation == OpWrite) && (32'(req_cell_bank) < MaxBanks)
                  && (32'(req_cell_row) < Rows) && (32'(req_cell_column) < Columns)
                  && (32'(req_frame_index) < FrameSize);
   logic signed [15:0] rdat[16];
   wmil_cell_store #(.MaxBanks(MaxBanks), .Rows(Rows), .Columns(Columns),
                     .FrameSize(FrameSize)) u_store (
      .clock    (clock),
      .wr_en    (wr_ok),
      .wr_bank  (BW'(req_cell_bank)),
      .wr_row   (RW'(req_cell_row)),
      .wr_column(CW'(req_cell_column)),
      .wr_index (FW'(req_frame_index)),
      .wr_data  (req_sample_value),
      .rd_en    (advance),
      .rd_bank  (rb),
      .rd_row   (rr),
      .rd_column(rc),
      .rd_index (ri),
      .rd_data  (rdat)
   );

   // pipeline registers
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [11:0] bf1_ff, rf1_ff, cf1_ff, bf2_ff, rf2_ff, cf2_ff;
   logic [11:0] rf3_ff, cf3_ff, cf4_ff;
   logic [15:0] g1_ff;
   logic signed [31:0] v2c_ff[8];
   logic signed [44:0] w3_ff[4];
   logic signed [57:0] w4_ff[2];
   logic signed [70:0] sum5_ff;
   logic signed [15:0] out_ff;

   // stage 2 lerp across the frame, stage 3..5 weight bank, row, column
   logic signed [31:0] lerp[8];
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         logic signed [40:0] t;
         t = ({{25{rdat[2*k][15]}}, rdat[2*k]} <<< 16)
             + (41'(signed'({rdat[2*k+1][15], rdat[2*k+1]}) - signed'({rdat[2*k][15], rdat[2*k]}))
                * signed'({25'd0, g1_ff}));
         lerp[k] = 32'(t >>> 8);
      end
   end

   logic [12:0] bw0, bw1, rw0, rw1, cw0, cw1;
   assign bw1 = {1'b0, bf2_ff};
   assign bw0 = 13'd4096 - bw1;
   assign rw1 = {1'b0, rf3_ff};
   assign rw0 = 13'd4096 - rw1;
   assign cw1 = {1'b0, cf4_ff};
   assign cw0 = 13'd4096 - cw1;

   logic signed [70:0] rnd;
   logic signed [26:0] q;
   assign rnd = sum5_ff + (71'sd1 <<< 43);
   assign q   = 27'(rnd >>> 44);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= take && (req_operation == OpRead);
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bf1_ff <= bp[11:0]; rf1_ff <= rp[11:0]; cf1_ff <= cp[11:0];
         g1_ff  <= pp[GW-1:0];
         bf2_ff <= bf1_ff; rf2_ff <= rf1_ff; cf2_ff <= cf1_ff;
         for (int k = 0; k < 8; k++) v2c_ff[k] <= lerp[k];
         rf3_ff <= rf2_ff; cf3_ff <= cf2_ff;
         for (int k = 0; k < 4; k++)
            w3_ff[k] <= 45'(v2c_ff[k] * signed'({1'b0, bw0}))
                      + 45'(v2c_ff[k+4] * signed'({1'b0, bw1}));
         cf4_ff <= cf3_ff;
         for (int k = 0; k < 2; k++)
            w4_ff[k] <= 58'(w3_ff[k] * signed'({1'b0, rw0}))
                      + 58'(w3_ff[k+2] * signed'({1'b0, rw1}));
         sum5_ff <= 71'(w4_ff[0] * signed'({1'b0, cw0}))
                  + 71'(w4_ff[1] * signed'({1'b0, cw1}));
         out_ff <= (q > 27'sd32767) ? 16'sh7fff :
                   (q < -27'sd32768) ? 16'sh8000 : 16'(q);
      end
   end

   assign rsp_valid      = v6_ff;
   assign rsp_sample_out = out_ff;

   // a held response must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("held response changed");
   // no request transfer while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken under stall");
   // bank count reset value
   assert property (@(posedge clock) reset |=> bank_count_ff == 5'd1)
      else $error("bank count not reset");
endmodule
`default_nettype wire
